>>> src/assert_macros.svh
// Assertion macros used by the checker module of this project.
// The macros expect i_clk and i_rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RVX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rvx checker: property failed");

// Next-cycle implication, disabled while reset is held.
`define RVX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rvx checker: property failed");

`endif

>>> src/rvx_pkg.sv
// Shared types and constants of the RV64I subset executor.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rvx_pkg;

    localparam int XLEN       = 64;
    localparam int ILEN       = 32;
    localparam int TRACE_W    = 16;
    localparam int REG_COUNT  = 32;
    localparam int RF_AW      = 5;
    localparam int DATA_WORDS = 128;
    localparam int DS_AW      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_LWU  = 3'd6;
    localparam logic [2:0] F3_LBAD = 3'd7;

    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [2:0] F3_SD   = 3'd3;

    localparam logic [2:0] F3_JALR = 3'd0;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    typedef struct packed {
        logic               rf_we;
        logic [RF_AW-1:0]   rf_addr;
        logic [XLEN-1:0]    rf_data;
        logic               dm_we;
        logic               dm_re;
        logic [DS_AW-1:0]   dm_addr;
        logic [XLEN-1:0]    dm_data;
        logic [TRACE_W-1:0] trace;
        logic [XLEN-1:0]    npc;
        logic               bad;
    } t_exu_res;

endpackage

`default_nettype wire

>>> src/rv64i_subset_executor_top.sv
// Top level of the RV64I subset executor: input register, execute logic,
// register file, data store and output register. Uses rvx_pkg, rvx_rf, rvx_dmem, rvx_exu.
`timescale 1ns / 1ps
`default_nettype none

// Executes one RV64I integer instruction per item and returns the low 16 bits of the
// written, stored or target value together with the next pc and an out-of-range flag.
// An item is latched together with its two source registers, read from the register
// file with forwarding of the result being written in the same cycle, and executes
// in the following cycle; a new item is taken every cycle unless the executing item
// is held by a stalled output or a pending load. A load that hits the data store waits
// for its data: the store has a single registered read port, addressed only once the
// load address is known. The register file and data store come out of reset all zero
// at once through per-entry valid bits; there is no clearing pass. The output register
// lets the next item start while a result waits to be taken.
module rv64i_subset_executor_top import rvx_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ILEN-1:0]    i_instruction,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [TRACE_W-1:0] o_trace_value,
    output logic [XLEN-1:0]    o_next_pc,
    output logic               o_bad_address
);

    logic               r_x_vld;
    logic [ILEN-1:0]    r_ins;
    logic [XLEN-1:0]    r_pc;
    logic               r_ld_wait;
    logic               r_o_vld;
    logic [TRACE_W-1:0] r_trace;
    logic [XLEN-1:0]    r_npc;
    logic               r_bad;

    logic [XLEN-1:0]    rf_rd1;
    logic [XLEN-1:0]    rf_rd2;
    logic [XLEN-1:0]    dm_rdata;
    t_exu_res           exu_res;
    logic               out_free;
    logic               x_done;
    logic               ld_issue;
    logic               in_acc;

    assign out_free   = !r_o_vld || !i_out_stall;
    assign x_done     = r_x_vld && (!exu_res.dm_re || r_ld_wait) && out_free;
    assign ld_issue   = r_x_vld && exu_res.dm_re && !r_ld_wait;
    assign o_in_stall = !i_rst_n || (r_x_vld && !x_done);
    assign in_acc     = i_in_valid && !o_in_stall;

    rvx_rf u_rf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (in_acc),
        .i_ra1   (i_instruction[19:15]),
        .i_ra2   (i_instruction[24:20]),
        .i_we    (x_done && exu_res.rf_we),
        .i_wa    (exu_res.rf_addr),
        .i_wd    (exu_res.rf_data),
        .o_rd1   (rf_rd1),
        .o_rd2   (rf_rd2)
    );

    rvx_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (x_done && exu_res.dm_we),
        .i_wa    (exu_res.dm_addr),
        .i_wd    (exu_res.dm_data),
        .i_re    (ld_issue),
        .i_ra    (exu_res.dm_addr),
        .o_rd    (dm_rdata)
    );

    rvx_exu u_exu (
        .i_ins     (r_ins),
        .i_pc      (r_pc),
        .i_a       (rf_rd1),
        .i_b       (rf_rd2),
        .i_ld_data (dm_rdata),
        .o_res     (exu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld   <= 1'b0;
            r_ld_wait <= 1'b0;
            r_o_vld   <= 1'b0;
            r_pc      <= '0;
        end else begin
            if (in_acc) begin
                r_x_vld <= 1'b1;
            end else if (x_done) begin
                r_x_vld <= 1'b0;
            end
            if (ld_issue) begin
                r_ld_wait <= 1'b1;
            end else if (x_done) begin
                r_ld_wait <= 1'b0;
            end
            if (x_done) begin
                r_o_vld <= 1'b1;
                r_pc    <= exu_res.npc;
            end else if (!i_out_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ins <= i_instruction;
        end
        if (x_done) begin
            r_trace <= exu_res.trace;
            r_npc   <= exu_res.npc;
            r_bad   <= exu_res.bad;
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_trace_value = r_trace;
    assign o_next_pc     = r_npc;
    assign o_bad_address = r_bad;

endmodule

`default_nettype wire

>>> src/rvx_rf.sv
// Integer register file: 32 x 64 bits, one write port, two registered read ports.
// Entries never written read as zero; a write in the read cycle is forwarded. Uses rvx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvx_rf import rvx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_re,
    input  logic [RF_AW-1:0]  i_ra1,
    input  logic [RF_AW-1:0]  i_ra2,
    input  logic              i_we,
    input  logic [RF_AW-1:0]  i_wa,
    input  logic [XLEN-1:0]   i_wd,
    output logic [XLEN-1:0]   o_rd1,
    output logic [XLEN-1:0]   o_rd2
);

    logic [XLEN-1:0]      r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [XLEN-1:0]      r_rd1;
    logic [XLEN-1:0]      r_rd2;
    logic                 wr_ok;

    assign wr_ok = i_we && (i_wa != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_ok) begin
            r_vld[i_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (wr_ok && (i_wa == i_ra1)) begin
                r_rd1 <= i_wd;
            end else begin
                r_rd1 <= r_vld[i_ra1] ? r_mem[i_ra1] : '0;
            end
            if (wr_ok && (i_wa == i_ra2)) begin
                r_rd2 <= i_wd;
            end else begin
                r_rd2 <= r_vld[i_ra2] ? r_mem[i_ra2] : '0;
            end
        end
    end

    assign o_rd1 = r_rd1;
    assign o_rd2 = r_rd2;

endmodule

`default_nettype wire

>>> src/rvx_dmem.sv
// Word-indexed data store with one write port and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses rvx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvx_dmem import rvx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [DS_AW-1:0]  i_wa,
    input  logic [XLEN-1:0]   i_wd,
    input  logic              i_re,
    input  logic [DS_AW-1:0]  i_ra,
    output logic [XLEN-1:0]   o_rd
);

    logic [XLEN-1:0]       r_mem [DATA_WORDS];
    logic [DATA_WORDS-1:0] r_vld;
    logic [XLEN-1:0]       r_rdata;
    logic                  r_rvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_ra];
            r_rvld  <= r_vld[i_ra];
        end
    end

    assign o_rd = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

>>> src/rvx_exu.sv
// Decode and execute logic for one instruction: ALU, address generation,
// branch resolution, load extraction and next-pc selection. Uses rvx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rvx_exu import rvx_pkg::*; (
    input  logic [ILEN-1:0] i_ins,
    input  logic [XLEN-1:0] i_pc,
    input  logic [XLEN-1:0] i_a,
    input  logic [XLEN-1:0] i_b,
    input  logic [XLEN-1:0] i_ld_data,
    output t_exu_res        o_res
);

    logic [6:0]      op;
    logic [2:0]      f3;
    logic [6:0]      f7;
    logic [RF_AW-1:0] rd;
    logic [XLEN-1:0] immi;
    logic [XLEN-1:0] imms;
    logic [XLEN-1:0] immb;
    logic [XLEN-1:0] immj;
    logic [XLEN-1:0] immu;
    logic            is_reg;
    logic            use_b;
    logic            is_sub;
    logic [XLEN-1:0] op2;
    logic [4:0]      shamt;
    logic [XLEN-1:0] alu_sum;
    logic [XLEN-1:0] sra_v;
    logic            eq;
    logic            lt_s;
    logic            lt_u;
    logic [XLEN-1:0] agen;
    logic            in_range;
    logic [XLEN-1:0] pc_off;
    logic [XLEN-1:0] pc_tgt;
    logic [XLEN-1:0] pc_inc;
    logic [XLEN-1:0] ld_v;
    logic [XLEN-1:0] st_v;
    logic            take;
    logic [XLEN-1:0] v;
    logic            wr;
    logic [XLEN-1:0] tv;

    assign op = i_ins[6:0];
    assign f3 = i_ins[14:12];
    assign f7 = i_ins[31:25];
    assign rd = i_ins[11:7];

    assign immi = {{52{i_ins[31]}}, i_ins[31:20]};
    assign imms = {{52{i_ins[31]}}, i_ins[31:25], i_ins[11:7]};
    assign immb = {{51{i_ins[31]}}, i_ins[31], i_ins[7], i_ins[30:25], i_ins[11:8], 1'b0};
    assign immj = {{43{i_ins[31]}}, i_ins[31], i_ins[19:12], i_ins[20], i_ins[30:21], 1'b0};
    assign immu = {{32{i_ins[31]}}, i_ins[31:12], 12'b0};

    assign is_reg  = (op == OP_REG);
    assign use_b   = is_reg || (op == OP_BRANCH);
    assign is_sub  = is_reg && (f7 == F7_ALT);
    assign op2     = use_b ? i_b : immi;
    assign shamt   = is_reg ? i_b[4:0] : i_ins[24:20];
    assign alu_sum = is_sub ? (i_a - op2) : (i_a + op2);
    assign sra_v   = $signed(i_a) >>> shamt;
    assign eq      = (i_a == op2);
    assign lt_s    = ($signed(i_a) < $signed(op2));
    assign lt_u    = (i_a < op2);

    assign agen     = i_a + ((op == OP_STORE) ? imms : immi);
    assign in_range = (agen < XLEN'(DATA_WORDS));

    assign pc_off = (op == OP_JAL) ? immj : ((op == OP_AUIPC) ? immu : immb);
    assign pc_tgt = i_pc + pc_off;
    assign pc_inc = i_pc + XLEN'(4);

    always_comb begin
        case (f3)
            F3_LB:   ld_v = {{56{i_ld_data[7]}}, i_ld_data[7:0]};
            F3_LH:   ld_v = {{48{i_ld_data[15]}}, i_ld_data[15:0]};
            F3_LW:   ld_v = {{32{i_ld_data[31]}}, i_ld_data[31:0]};
            F3_LD:   ld_v = i_ld_data;
            F3_LBU:  ld_v = {56'b0, i_ld_data[7:0]};
            F3_LHU:  ld_v = {48'b0, i_ld_data[15:0]};
            F3_LWU:  ld_v = {32'b0, i_ld_data[31:0]};
            default: ld_v = '0;
        endcase
    end

    always_comb begin
        case (f3)
            F3_SB:   st_v = {56'b0, i_b[7:0]};
            F3_SH:   st_v = {48'b0, i_b[15:0]};
            F3_SW:   st_v = {32'b0, i_b[31:0]};
            default: st_v = i_b;
        endcase
    end

    always_comb begin
        case (f3)
            F3_BEQ:  take = eq;
            F3_BNE:  take = !eq;
            F3_BLT:  take = lt_s;
            F3_BGE:  take = !lt_s;
            F3_BLTU: take = lt_u;
            F3_BGEU: take = !lt_u;
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        o_res         = '0;
        o_res.npc     = pc_inc;
        o_res.rf_addr = rd;
        o_res.dm_addr = agen[DS_AW-1:0];
        o_res.dm_data = st_v;
        v             = '0;
        wr            = 1'b0;
        tv            = '0;
        case (op)
            OP_REG, OP_IMM: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD: begin
                        v = alu_sum;
                        if (is_reg && (f7 != F7_BASE) && (f7 != F7_ALT)) begin
                            wr = 1'b0;
                        end
                    end
                    F3_SLL:  v = i_a << shamt;
                    F3_SLT:  v = {63'b0, lt_s};
                    F3_SLTU: v = {63'b0, lt_u};
                    F3_XOR:  v = i_a ^ op2;
                    F3_SR: begin
                        if (f7 == F7_BASE) begin
                            v = i_a >> shamt;
                        end else if (f7 == F7_ALT) begin
                            v = sra_v;
                        end else begin
                            wr = 1'b0;
                        end
                    end
                    F3_OR:   v = i_a | op2;
                    default: v = i_a & op2;
                endcase
            end
            OP_LOAD: begin
                if (f3 != F3_LBAD) begin
                    if (!in_range) begin
                        o_res.bad = 1'b1;
                    end else begin
                        o_res.dm_re = 1'b1;
                        wr          = 1'b1;
                        v           = ld_v;
                    end
                end
            end
            OP_STORE: begin
                if ((f3 == F3_SB) || (f3 == F3_SH) || (f3 == F3_SW) || (f3 == F3_SD)) begin
                    if (!in_range) begin
                        o_res.bad = 1'b1;
                    end else begin
                        o_res.dm_we = 1'b1;
                        tv          = st_v;
                    end
                end
            end
            OP_LUI: begin
                wr = 1'b1;
                v  = immu;
            end
            OP_AUIPC: begin
                wr = 1'b1;
                v  = pc_tgt;
            end
            OP_JAL: begin
                o_res.npc     = pc_tgt;
                o_res.rf_we   = (rd != '0);
                o_res.rf_data = pc_inc;
                tv            = pc_tgt;
            end
            OP_JALR: begin
                if (f3 == F3_JALR) begin
                    o_res.npc     = {agen[XLEN-1:1], 1'b0};
                    o_res.rf_we   = (rd != '0);
                    o_res.rf_data = pc_inc;
                    tv            = {agen[XLEN-1:1], 1'b0};
                end
            end
            OP_BRANCH: begin
                if (take) begin
                    o_res.npc = pc_tgt;
                    tv        = pc_tgt;
                end
            end
            default: begin
                wr = 1'b0;
            end
        endcase
        if (wr) begin
            o_res.rf_we   = (rd != '0);
            o_res.rf_data = v;
            tv            = v;
        end
        o_res.trace = tv[TRACE_W-1:0];
    end

endmodule

`default_nettype wire

>>> src/rvx_checker.sv
// Port-level checker for the RV64I subset executor and its bind to the top level.
// Depends on assert_macros.svh and rvx_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rvx_checker import rvx_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [TRACE_W-1:0] o_trace_value,
    input logic [XLEN-1:0]    o_next_pc,
    input logic               o_bad_address
);

    `RVX_ASSERT_NXT(a_out_valid_hold, o_out_valid && i_out_stall, o_out_valid)
    `RVX_ASSERT_NXT(a_out_data_hold, o_out_valid && i_out_stall, $stable(o_trace_value) && $stable(o_next_pc) && $stable(o_bad_address))
    `RVX_ASSERT_IMP(a_bad_no_trace, o_out_valid && o_bad_address, o_trace_value == '0)
    `RVX_ASSERT_IMP(a_pc_even, o_out_valid, !o_next_pc[0])

endmodule

bind rv64i_subset_executor_top rvx_checker u_rvx_checker (.*);

`default_nettype wire
